### rtl/core/nspl_pkg.sv
// Shared types, constants, and the byte-distance and length-mask functions
// for the negative-selection pattern learner. No dependencies.
package nspl_pkg;

    // Result status codes
    localparam logic [2:0] ST_ADDED       = 3'd0;
    localparam logic [2:0] ST_SIMILAR     = 3'd1;
    localparam logic [2:0] ST_REPLACED    = 3'd2;
    localparam logic [2:0] ST_STORE_RESET = 3'd3;
    localparam logic [2:0] ST_DET_ADDED   = 3'd4;
    localparam logic [2:0] ST_GEN_FAILED  = 3'd5;
    localparam logic [2:0] ST_DET_FULL    = 3'd6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AFFINITY          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CAPACITY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTOR_CAPACITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LOW          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_HIGH         = 3'd5;

    // Reset values of the configuration registers
    localparam logic [3:0]  RST_PATTERN_LENGTH = 4'd6;
    localparam logic [3:0]  RST_AFFINITY       = 4'd4;
    localparam logic [8:0]  RST_CAPACITY       = 9'd256;
    localparam logic [63:0] RST_SEED_LOW       = 64'd1;
    localparam logic [63:0] RST_SEED_HIGH      = 64'd0;

    // Modulo-95 by reciprocal: q = (x * MOD_MUL) >> MOD_SHIFT is exact for 32-bit x
    localparam logic [32:0] MOD_MUL    = 33'd5786903305;
    localparam int          MOD_SHIFT  = 39;
    localparam logic [31:0] MOD_DIV    = 32'd95;
    localparam logic [7:0]  PRINT_BASE = 8'd32;

    // Sequencer states
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_LS_RD  = 14'b00000000000010,
        S_LS_CMP = 14'b00000000000100,
        S_LF_RD  = 14'b00000000001000,
        S_LF_CMP = 14'b00000000010000,
        S_LF_END = 14'b00000000100000,
        S_DS_RD  = 14'b00000001000000,
        S_DS_CMP = 14'b00000010000000,
        S_DR_BYT = 14'b00000100000000,
        S_DR_WT  = 14'b00001000000000,
        S_DR_RD  = 14'b00010000000000,
        S_DR_CMP = 14'b00100000000000,
        S_DR_END = 14'b01000000000000,
        S_FINISH = 14'b10000000000000
    } state_t;

    // Random unit control
    typedef struct packed {
        logic step;
        logic load_low;
        logic load_high;
    } rng_ctrl_t;

    // One result beat
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] slot;
        logic [8:0] replaced;
        logic [8:0] zeroed;
        logic [8:0] pcount;
        logic [8:0] dcount;
    } res_t;

    // Count differing bytes among the first n bytes
    function automatic logic [3:0] byte_dist(input logic [63:0] a, input logic [63:0] b,
                                             input logic [3:0] n);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if ((4'(i) < n) && (a[8*i +: 8] != b[8*i +: 8])) begin
                d = d + 4'd1;
            end
        end
        return d;
    endfunction

    // Keep the first n bytes
    function automatic logic [63:0] len_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

### rtl/core/nspl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nspl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/nspl_rng.sv
// xorshift128 generator with a three-stage modulo-95 reduction to a printable byte.
// Depends on nspl_pkg.
module nspl_rng (
    input  logic               clk,
    input  logic               rst_n,
    input  nspl_pkg::rng_ctrl_t ctrl,
    input  logic [63:0]        seed,
    output logic               done,
    output logic [7:0]         rbyte
);

    logic [31:0] s0_reg, s1_reg, s2_reg, s3_reg;
    logic [31:0] s3_next, t;
    logic [31:0] w_reg, w2_reg;
    logic [64:0] prod_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic [25:0] q;
    logic [31:0] r;
    logic [7:0]  byte_reg;

    // Next xorshift word
    always_comb
    begin
        t       = s0_reg ^ (s0_reg << 11);
        s3_next = (s3_reg ^ (s3_reg >> 19)) ^ (t ^ (t >> 8));
    end

    // Advance or reload the generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= nspl_pkg::RST_SEED_LOW[31:0];
            s1_reg <= nspl_pkg::RST_SEED_LOW[63:32];
            s2_reg <= nspl_pkg::RST_SEED_HIGH[31:0];
            s3_reg <= nspl_pkg::RST_SEED_HIGH[63:32];
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load_low)
            begin
                s0_reg <= seed[31:0];
                s1_reg <= seed[63:32];
            end
            if (ctrl.load_high)
            begin
                s2_reg <= seed[31:0];
                s3_reg <= seed[63:32];
            end
            if (ctrl.step)
            begin
                s0_reg <= s1_reg;
                s1_reg <= s2_reg;
                s2_reg <= s3_reg;
                s3_reg <= s3_next;
            end
            v1_reg <= ctrl.step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Reduce modulo 95 through a reciprocal product
    assign q = prod_reg[64:nspl_pkg::MOD_SHIFT];
    assign r = w2_reg - 32'(32'(q) * nspl_pkg::MOD_DIV);

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            w_reg <= s3_next;
        end
        prod_reg <= 65'(w_reg) * 65'(nspl_pkg::MOD_MUL);
        w2_reg   <= w_reg;
        byte_reg <= 8'(r[6:0]) + nspl_pkg::PRINT_BASE;
    end

    assign done  = v3_reg;
    assign rbyte = byte_reg;

endmodule

### rtl/core/negative_selection_pattern_learner.sv
// Top level of the negative-selection pattern learner: sequencer, stores and
// shared distance unit. Depends on nspl_pkg, nspl_ram and nspl_rng.
//
// Usage:
//   Input channel in_valid/in_ready carries action and pattern; output
//   channel out_valid/out_ready carries one result beat per input beat.
//   cfg_write/cfg_index/cfg_data write a register; write only while idle.
//   A seed write reloads the random state at once.
//   One item is handled at a time; in_ready is high only while idle.
//   Every store entry visited passes through an address state, then its
//   registered read data goes into the distance unit. Each drawn byte is
//   stepped through the random unit, and the draw is then checked against
//   the stored patterns. A learn item walks the stores and takes, for each
//   regenerated detector, up to MAX_ATTEMPTS draws and one commit.
//   A generate item takes up to MAX_ATTEMPTS draws and one commit.
//   Reset empties both stores (fill counts to zero), loads the register
//   defaults and the default seed; no clearing pass is needed.
//   A finished result sits in the output register while the receiver
//   stalls; the next item is accepted, and holds at its end until the
//   output register is free.
module negative_selection_pattern_learner #(
    parameter int PATTERN_DEPTH     = 256,
    parameter int DETECTOR_DEPTH    = 256,
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int MAX_ATTEMPTS      = 255
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [nspl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [63:0]                    pattern,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     status,
    output logic [7:0]                     slot,
    output logic [8:0]                     detectors_replaced,
    output logic [8:0]                     detectors_zeroed,
    output logic [8:0]                     patterns_held,
    output logic [8:0]                     detectors_held
);

    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int DAW = (DETECTOR_DEPTH > 1) ? $clog2(DETECTOR_DEPTH) : 1;
    localparam int PCW = $clog2(PATTERN_DEPTH + 1);
    localparam int DCW = $clog2(DETECTOR_DEPTH + 1);

    // Configuration
    logic [3:0] plen_reg, aff_reg;
    logic [8:0] pcap_reg, dcap_reg;

    // Control
    nspl_pkg::state_t state_reg, state_next;
    logic [PCW-1:0]   pfill_reg, pfill_next;
    logic [DCW-1:0]   dfill_reg, dfill_next;
    logic             out_valid_reg, out_valid_next;

    // Working payload
    logic [63:0]      pat_reg, pat_next, cand_reg, cand_next;
    logic             gen_reg, gen_next, ok_reg, ok_next, found_reg, found_next;
    logic [PCW-1:0]   pidx_reg, pidx_next, best_reg, best_next;
    logic [DCW-1:0]   didx_reg, didx_next, repl_reg, repl_next, zero_reg, zero_next;
    logic [3:0]       bd_reg, bd_next, bidx_reg, bidx_next;
    logic [7:0]       att_reg, att_next;
    logic [2:0]       st_reg, st_next;
    logic [7:0]       slot_reg, slot_next;
    nspl_pkg::res_t   out_reg, out_next;

    // Store ports and shared units
    logic             p_we, d_we;
    logic [PAW-1:0]   p_waddr;
    logic [DAW-1:0]   d_waddr;
    logic [63:0]      p_wdata, d_wdata, p_rdata, d_rdata;
    logic [63:0]      dist_a, dist_b;
    logic [3:0]       byte_diffs, n_eff;
    logic [31:0]      pcap_eff, dcap_eff;
    logic             rng_done;
    logic [7:0]       rng_byte;
    nspl_pkg::rng_ctrl_t rng_ctrl;

    nspl_ram #(.WIDTH(64), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (pidx_reg[PAW-1:0]),
        .rdata (p_rdata)
    );

    nspl_ram #(.WIDTH(64), .DEPTH(DETECTOR_DEPTH)) u_det_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (didx_reg[DAW-1:0]),
        .rdata (d_rdata)
    );

    nspl_rng u_rng (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rng_ctrl),
        .seed  (cfg_data),
        .done  (rng_done),
        .rbyte (rng_byte)
    );

    // Effective length and capacities
    always_comb
    begin
        n_eff    = (32'(plen_reg) > 32'(MAX_PATTERN_BYTES)) ? 4'(MAX_PATTERN_BYTES) : plen_reg;
        pcap_eff = (32'(pcap_reg) > 32'(PATTERN_DEPTH)) ? 32'(PATTERN_DEPTH) : 32'(pcap_reg);
        dcap_eff = (32'(dcap_reg) > 32'(DETECTOR_DEPTH)) ? 32'(DETECTOR_DEPTH) : 32'(dcap_reg);
    end

    // Shared distance unit
    assign dist_a     = (state_reg == nspl_pkg::S_DS_CMP) ? d_rdata : p_rdata;
    assign dist_b     = (state_reg == nspl_pkg::S_DR_CMP) ? cand_reg : pat_reg;
    assign byte_diffs = nspl_pkg::byte_dist(dist_a, dist_b, n_eff);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        pfill_next     = pfill_reg;
        dfill_next     = dfill_reg;
        out_valid_next = out_valid_reg;
        pat_next       = pat_reg;
        cand_next      = cand_reg;
        gen_next       = gen_reg;
        ok_next        = ok_reg;
        found_next     = found_reg;
        pidx_next      = pidx_reg;
        best_next      = best_reg;
        didx_next      = didx_reg;
        repl_next      = repl_reg;
        zero_next      = zero_reg;
        bd_next        = bd_reg;
        bidx_next      = bidx_reg;
        att_next       = att_reg;
        st_next        = st_reg;
        slot_next      = slot_reg;
        out_next       = out_reg;
        p_we           = 1'b0;
        p_waddr        = pfill_reg[PAW-1:0];
        p_wdata        = pat_reg;
        d_we           = 1'b0;
        d_waddr        = didx_reg[DAW-1:0];
        d_wdata        = cand_reg;
        rng_ctrl.step      = 1'b0;
        rng_ctrl.load_low  = cfg_write && (cfg_index == nspl_pkg::CFG_SEED_LOW);
        rng_ctrl.load_high = cfg_write && (cfg_index == nspl_pkg::CFG_SEED_HIGH);

        // Drop the output beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            nspl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    pat_next  = pattern & nspl_pkg::len_mask(n_eff);
                    pidx_next = '0;
                    didx_next = '0;
                    repl_next = '0;
                    zero_next = '0;
                    slot_next = '0;
                    bd_next   = 4'd1;
                    best_next = '0;
                    found_next = 1'b0;
                    att_next  = '0;
                    bidx_next = '0;
                    cand_next = '0;
                    gen_next  = action;
                    if (!action)
                    begin
                        state_next = (32'(pfill_reg) < pcap_eff) ? nspl_pkg::S_LS_RD
                                                                 : nspl_pkg::S_LF_RD;
                    end
                    else if (32'(dfill_reg) < dcap_eff)
                    begin
                        state_next = nspl_pkg::S_DR_BYT;
                    end
                    else
                    begin
                        st_next    = nspl_pkg::ST_DET_FULL;
                        state_next = nspl_pkg::S_FINISH;
                    end
                end
            end

            // Look for a similar stored pattern; add when none
            nspl_pkg::S_LS_RD:
            begin
                if (pidx_reg >= pfill_reg)
                begin
                    p_we       = 1'b1;
                    slot_next  = 8'(pfill_reg);
                    pfill_next = pfill_reg + 1'b1;
                    st_next    = nspl_pkg::ST_ADDED;
                    state_next = nspl_pkg::S_DS_RD;
                end
                else
                begin
                    state_next = nspl_pkg::S_LS_CMP;
                end
            end

            nspl_pkg::S_LS_CMP:
            begin
                if (byte_diffs < aff_reg)
                begin
                    st_next    = nspl_pkg::ST_SIMILAR;
                    state_next = nspl_pkg::S_FINISH;
                end
                else
                begin
                    pidx_next  = pidx_reg + 1'b1;
                    state_next = nspl_pkg::S_LS_RD;
                end
            end

            // Full store: replace the most distant pattern beyond the affinity; empty the store when there is none
            nspl_pkg::S_LF_RD:
            begin
                state_next = (pidx_reg >= pfill_reg) ? nspl_pkg::S_LF_END : nspl_pkg::S_LF_CMP;
            end

            nspl_pkg::S_LF_CMP:
            begin
                if ((byte_diffs > aff_reg) && (byte_diffs > bd_reg))
                begin
                    bd_next    = byte_diffs;
                    best_next  = pidx_reg;
                    found_next = 1'b1;
                end
                pidx_next  = pidx_reg + 1'b1;
                state_next = (bd_next == n_eff) ? nspl_pkg::S_LF_END : nspl_pkg::S_LF_RD;
            end

            nspl_pkg::S_LF_END:
            begin
                if (found_reg)
                begin
                    p_we      = 1'b1;
                    p_waddr   = best_reg[PAW-1:0];
                    slot_next = 8'(best_reg);
                    st_next   = nspl_pkg::ST_REPLACED;
                end
                else
                begin
                    pfill_next = '0;
                    st_next    = nspl_pkg::ST_STORE_RESET;
                end
                state_next = nspl_pkg::S_FINISH;
            end

            // Walk detectors against the new pattern
            nspl_pkg::S_DS_RD:
            begin
                state_next = (didx_reg >= dfill_reg) ? nspl_pkg::S_FINISH : nspl_pkg::S_DS_CMP;
            end

            nspl_pkg::S_DS_CMP:
            begin
                if (byte_diffs < aff_reg)
                begin
                    att_next   = '0;
                    bidx_next  = '0;
                    cand_next  = '0;
                    state_next = nspl_pkg::S_DR_BYT;
                end
                else
                begin
                    didx_next  = didx_reg + 1'b1;
                    state_next = nspl_pkg::S_DS_RD;
                end
            end

            // Draw one candidate byte by byte
            nspl_pkg::S_DR_BYT:
            begin
                if (bidx_reg < n_eff)
                begin
                    rng_ctrl.step = 1'b1;
                    state_next    = nspl_pkg::S_DR_WT;
                end
                else
                begin
                    pidx_next  = '0;
                    state_next = nspl_pkg::S_DR_RD;
                end
            end

            nspl_pkg::S_DR_WT:
            begin
                if (rng_done)
                begin
                    cand_next[{bidx_reg[2:0], 3'b000} +: 8] = rng_byte;
                    bidx_next  = bidx_reg + 4'd1;
                    state_next = nspl_pkg::S_DR_BYT;
                end
            end

            // Check the candidate against every stored pattern
            nspl_pkg::S_DR_RD:
            begin
                if (pidx_reg >= pfill_reg)
                begin
                    ok_next    = 1'b1;
                    state_next = nspl_pkg::S_DR_END;
                end
                else
                begin
                    state_next = nspl_pkg::S_DR_CMP;
                end
            end

            nspl_pkg::S_DR_CMP:
            begin
                if (byte_diffs < aff_reg)
                begin
                    if ((9'(att_reg) + 9'd1) >= 9'(MAX_ATTEMPTS))
                    begin
                        ok_next    = 1'b0;
                        state_next = nspl_pkg::S_DR_END;
                    end
                    else
                    begin
                        att_next   = att_reg + 8'd1;
                        bidx_next  = '0;
                        cand_next  = '0;
                        state_next = nspl_pkg::S_DR_BYT;
                    end
                end
                else
                begin
                    pidx_next  = pidx_reg + 1'b1;
                    state_next = nspl_pkg::S_DR_RD;
                end
            end

            // Commit the draw
            nspl_pkg::S_DR_END:
            begin
                if (gen_reg)
                begin
                    if (ok_reg)
                    begin
                        d_we       = 1'b1;
                        d_waddr    = dfill_reg[DAW-1:0];
                        slot_next  = 8'(dfill_reg);
                        dfill_next = dfill_reg + 1'b1;
                        st_next    = nspl_pkg::ST_DET_ADDED;
                    end
                    else
                    begin
                        st_next = nspl_pkg::ST_GEN_FAILED;
                    end
                    state_next = nspl_pkg::S_FINISH;
                end
                else
                begin
                    d_we = 1'b1;
                    if (ok_reg)
                    begin
                        repl_next = repl_reg + 1'b1;
                    end
                    else
                    begin
                        d_wdata   = '0;
                        zero_next = zero_reg + 1'b1;
                    end
                    didx_next  = didx_reg + 1'b1;
                    state_next = nspl_pkg::S_DS_RD;
                end
            end

            // Hand the result to the output register
            nspl_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status   = st_reg;
                    out_next.slot     = slot_reg;
                    out_next.replaced = 9'(repl_reg);
                    out_next.zeroed   = 9'(zero_reg);
                    out_next.pcount   = 9'(pfill_reg);
                    out_next.dcount   = 9'(dfill_reg);
                    out_valid_next    = 1'b1;
                    state_next        = nspl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = nspl_pkg::S_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nspl_pkg::S_IDLE;
            pfill_reg     <= '0;
            dfill_reg     <= '0;
            out_valid_reg <= 1'b0;
            plen_reg      <= nspl_pkg::RST_PATTERN_LENGTH;
            aff_reg       <= nspl_pkg::RST_AFFINITY;
            pcap_reg      <= nspl_pkg::RST_CAPACITY;
            dcap_reg      <= nspl_pkg::RST_CAPACITY;
        end
        else
        begin
            state_reg     <= state_next;
            pfill_reg     <= pfill_next;
            dfill_reg     <= dfill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    nspl_pkg::CFG_PATTERN_LENGTH:    plen_reg <= cfg_data[3:0];
                    nspl_pkg::CFG_AFFINITY:          aff_reg  <= cfg_data[3:0];
                    nspl_pkg::CFG_PATTERN_CAPACITY:  pcap_reg <= cfg_data[8:0];
                    nspl_pkg::CFG_DETECTOR_CAPACITY: dcap_reg <= cfg_data[8:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        pat_reg   <= pat_next;
        cand_reg  <= cand_next;
        gen_reg   <= gen_next;
        ok_reg    <= ok_next;
        found_reg <= found_next;
        pidx_reg  <= pidx_next;
        best_reg  <= best_next;
        didx_reg  <= didx_next;
        repl_reg  <= repl_next;
        zero_reg  <= zero_next;
        bd_reg    <= bd_next;
        bidx_reg  <= bidx_next;
        att_reg   <= att_next;
        st_reg    <= st_next;
        slot_reg  <= slot_next;
        out_reg   <= out_next;
    end

    assign in_ready           = (state_reg == nspl_pkg::S_IDLE);
    assign out_valid          = out_valid_reg;
    assign status             = out_reg.status;
    assign slot               = out_reg.slot;
    assign detectors_replaced = out_reg.replaced;
    assign detectors_zeroed   = out_reg.zeroed;
    assign patterns_held      = out_reg.pcount;
    assign detectors_held     = out_reg.dcount;

endmodule
